// File: rtl/core/cpfc_pkg.sv
// Package for the cursor pixel format converter: codes, pixel and result
// structs, classification flags and the premultiply helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpfc_pkg;

    localparam int unsigned ByteW = 8;

    // Item operation codes
    typedef enum logic {
        OP_SCAN    = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    // Cursor type codes on the result channel
    typedef enum logic [1:0] {
        CT_COLOUR = 2'd0,
        CT_MASKED = 2'd1,
        CT_MONO   = 2'd2
    } cursor_type_t;

    typedef struct packed {
        logic [ByteW-1:0] blue;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] alpha;
        logic [ByteW-1:0] mask_byte;
    } pixel_t;

    typedef struct packed {
        cursor_type_t     cursor_type;
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
        logic [ByteW-1:0] alpha;
    } texel_t;

    // Classification flags gathered over the scan pass
    typedef struct packed {
        logic any_alpha;
        logic masked_conflict;
        logic mono_conflict;
    } flags_t;

    // round(c*a/255); exact for 8-bit operands, ties cannot occur
    function automatic logic [ByteW-1:0] premul(input logic [ByteW-1:0] c,
                                                input logic [ByteW-1:0] a);
        logic [2*ByteW-1:0] prod;
        logic [2*ByteW:0]   rnd;
        logic [2*ByteW:0]   sum;
        prod = c * a;
        rnd  = {1'b0, prod} + (2*ByteW+1)'(128);
        sum  = rnd + (rnd >> ByteW);
        return sum[2*ByteW-1:ByteW];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cpfc_pixel_logic.sv
// Per-pixel logic: classification flag update for scan beats and texel
// selection for convert beats. Depends on cpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpfc_pixel_logic (
    input  wire logic            first,
    input  wire cpfc_pkg::pixel_t pix,
    input  wire cpfc_pkg::flags_t flags,
    input  wire logic            colour_present,
    output cpfc_pkg::flags_t     flags_next,
    output cpfc_pkg::texel_t     texel
);
    import cpfc_pkg::*;

    logic rgb_nz;
    logic blue_nz;
    logic mask_nz;
    logic alpha_nz;
    flags_t base;

    assign rgb_nz   = (pix.red != '0) || (pix.green != '0) || (pix.blue != '0);
    assign blue_nz  = (pix.blue != '0);
    assign mask_nz  = (pix.mask_byte != '0);
    assign alpha_nz = (pix.alpha != '0);

    // Clear on the first scan beat, then accumulate
    always_comb begin
        base       = first ? '0 : flags;
        flags_next.any_alpha       = base.any_alpha | alpha_nz;
        flags_next.masked_conflict = base.masked_conflict | (mask_nz & rgb_nz);
        flags_next.mono_conflict   = base.mono_conflict | (blue_nz & mask_nz);
    end

    // Select the texel from the cursor class
    always_comb begin
        texel = '{cursor_type: CT_COLOUR, red: '0, green: '0, blue: '0, alpha: '0};
        if (colour_present) begin
            if (flags.any_alpha) begin
                texel.red   = premul(pix.red, pix.alpha);
                texel.green = premul(pix.green, pix.alpha);
                texel.blue  = premul(pix.blue, pix.alpha);
                texel.alpha = 8'hFF - pix.alpha;
            end else if (!flags.masked_conflict) begin
                if (!mask_nz) begin
                    texel.red   = pix.red;
                    texel.green = pix.green;
                    texel.blue  = pix.blue;
                    texel.alpha = pix.alpha;
                end else begin
                    texel.alpha = 8'hFF;
                end
            end else begin
                texel.cursor_type = CT_MASKED;
                texel.red   = pix.red;
                texel.green = pix.green;
                texel.blue  = pix.blue;
                texel.alpha = pix.mask_byte;
            end
        end else if (!flags.mono_conflict) begin
            if (blue_nz) begin
                texel.alpha = 8'hFF;
            end else if (mask_nz) begin
                texel.red   = 8'hFF;
                texel.green = 8'hFF;
                texel.blue  = 8'hFF;
            end
        end else begin
            texel.cursor_type = CT_MONO;
            texel.red   = pix.blue;
            texel.green = pix.mask_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cursor_pixel_format_converter.sv
// Top level of the cursor pixel format converter: input stage, flag
// registers, result register. Depends on cpfc_pkg and cpfc_pixel_logic.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Software streams each cursor twice over the s_ channel. Scan beats
//   (operation 0, first set on the first pixel) build the classification
//   flags and produce no result. Convert beats (operation 1) each return one
//   texel and the cursor type on the m_ channel.
//   The cfg_ channel writes colour_bitmap_present and is always ready; it is
//   to be written while the block is idle, which the block does not enforce.
//   A convert beat passes two register stages: input and result register.
//   Throughput: one beat per cycle unless a convert beat waits on a held
//   result register; the only per-beat work is three 8x8 multiplies with
//   rounding between the two registers.
//   When m_ready is low the result register holds; the input stage keeps
//   taking beats until it is full, and scan beats still drain through it.
//   Reset (aresetn low, synchronous) empties both stages and clears the
//   flags and the configuration register.
module cursor_pixel_format_converter (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_colour_bitmap_present,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_operation,
    input  wire logic       s_first,
    input  wire logic [7:0] s_blue,
    input  wire logic [7:0] s_green,
    input  wire logic [7:0] s_red,
    input  wire logic [7:0] s_alpha,
    input  wire logic [7:0] s_mask_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_cursor_type,
    output logic [7:0]      m_out_red,
    output logic [7:0]      m_out_green,
    output logic [7:0]      m_out_blue,
    output logic [7:0]      m_out_alpha
);
    import cpfc_pkg::*;

    logic   colour_reg;
    logic   in_valid_reg;
    op_t    in_op_reg;
    logic   in_first_reg;
    pixel_t in_pix_reg;
    flags_t flags_reg;
    flags_t flags_next;
    logic   out_valid_reg;
    texel_t out_texel_reg;
    texel_t texel;
    logic   out_free;
    logic   out_load;
    logic   stage_adv;
    logic   scan_adv;

    assign cfg_ready = 1'b1;

    // Stage handshake: scan beats leave freely, convert beats need the result slot
    assign out_free  = !out_valid_reg || m_ready;
    assign out_load  = in_valid_reg && (in_op_reg == OP_CONVERT) && out_free;
    assign scan_adv  = in_valid_reg && (in_op_reg == OP_SCAN);
    assign stage_adv = scan_adv || out_load;
    assign s_ready   = !in_valid_reg || stage_adv;

    cpfc_pixel_logic u_pixel_logic (
        .first          (in_first_reg),
        .pix            (in_pix_reg),
        .flags          (flags_reg),
        .colour_present (colour_reg),
        .flags_next     (flags_next),
        .texel          (texel)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            colour_reg <= cfg_colour_bitmap_present;
        end
    end

    // Input stage: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input stage: payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= op_t'(s_operation);
            in_first_reg <= s_first;
            in_pix_reg   <= '{blue: s_blue, green: s_green, red: s_red,
                              alpha: s_alpha, mask_byte: s_mask_byte};
        end
    end

    // Classification flags: advance on each scan beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (scan_adv) begin
            flags_reg <= flags_next;
        end
    end

    // Result register: load on convert, drop on take
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_texel_reg <= texel;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_cursor_type = out_texel_reg.cursor_type;
    assign m_out_red     = out_texel_reg.red;
    assign m_out_green   = out_texel_reg.green;
    assign m_out_blue    = out_texel_reg.blue;
    assign m_out_alpha   = out_texel_reg.alpha;

    // Checks
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && (in_op_reg == OP_CONVERT) && out_valid_reg)
        else $error("input stage stalled without a blocked convert beat");

    a_convert_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("convert beat did not reach the result register");

    a_alpha_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_adv && (in_pix_reg.alpha != '0) |=> flags_reg.any_alpha)
        else $error("nonzero alpha in scan did not set the flag");

    a_mono_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_cursor_type == CT_MONO) |-> (m_out_blue == '0) && (m_out_alpha == '0))
        else $error("monochrome texel with nonzero blue or alpha");

    a_masked_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (texel.cursor_type == CT_MASKED) |-> colour_reg && !flags_reg.any_alpha)
        else $error("masked type without a colour bitmap");

endmodule

`default_nettype wire

// File: tb/cursor_pixel_format_converter_tb.sv
// Self-checking testbench for cursor_pixel_format_converter: clocked driver and
// monitor around the DUT, an in-bench prediction of each texel, random idling.
// Depends on cpfc_pkg and the cursor_pixel_format_converter RTL.
`timescale 1ns / 1ps

module cursor_pixel_format_converter_tb;

    import cpfc_pkg::*;

    localparam int StallLimit = 2000;   // quiet cycles before the run is abandoned
    localparam int HoldCycles = 200;    // long receiver hold-off
    localparam int HoldEvery  = 260;    // texels between hold-offs

    typedef struct packed {
        op_t        op;
        logic       first;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [7:0] mask_byte;
    } pixel_beat_t;

    typedef enum int {STYLE_ALPHA, STYLE_MASKED, STYLE_MONO, STYLE_RAW} cursor_style_t;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_colour_bitmap_present = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_operation = 1'b0;
    logic       s_first = 1'b0;
    logic [7:0] s_blue = 8'd0;
    logic [7:0] s_green = 8'd0;
    logic [7:0] s_red = 8'd0;
    logic [7:0] s_alpha = 8'd0;
    logic [7:0] s_mask_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_cursor_type;
    logic [7:0] m_out_red;
    logic [7:0] m_out_green;
    logic [7:0] m_out_blue;
    logic [7:0] m_out_alpha;

    // Pending stimulus, expected texels and the mirrored block state
    pixel_beat_t pending_beats[$];
    texel_t      expected_texels[$];
    logic        cfg_requests[$];
    pixel_beat_t offered = '0;
    flags_t      scan_flags = '0;
    logic        colour_bitmap_model = 1'b0;

    int beats_queued     = 0;
    int beats_accepted   = 0;
    int cfg_writes_asked = 0;
    int cfg_writes_done  = 0;
    int mismatches       = 0;
    int quiet_cycles     = 0;

    // Driver pacing
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver pacing
    int       texels_checked = 0;
    int       next_hold_at   = 30;
    int       hold_left      = 0;
    int       mode_left      = 0;
    int       rx_tick        = 0;
    rx_mode_t rx_mode        = RX_ALWAYS;

    cursor_pixel_format_converter DUT (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .cfg_valid                 (cfg_valid),
        .cfg_ready                 (cfg_ready),
        .cfg_colour_bitmap_present (cfg_colour_bitmap_present),
        .s_valid                   (s_valid),
        .s_ready                   (s_ready),
        .s_operation               (s_operation),
        .s_first                   (s_first),
        .s_blue                    (s_blue),
        .s_green                   (s_green),
        .s_red                     (s_red),
        .s_alpha                   (s_alpha),
        .s_mask_byte               (s_mask_byte),
        .m_valid                   (m_valid),
        .m_ready                   (m_ready),
        .m_cursor_type             (m_cursor_type),
        .m_out_red                 (m_out_red),
        .m_out_green               (m_out_green),
        .m_out_blue                (m_out_blue),
        .m_out_alpha               (m_out_alpha)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // round(c*a/255) done exactly in integers
    function automatic logic [7:0] alpha_scaled(input logic [7:0] c, input logic [7:0] a);
        int unsigned twice;
        twice = 2 * c * a + 255;
        return 8'(twice / 510);
    endfunction

    // Fold a scan beat into the flags, or build the texel of a convert beat
    function automatic bit apply_pixel_beat(input pixel_beat_t bt, output texel_t tx);
        tx = '0;
        if (bt.op == OP_SCAN) begin
            if (bt.first) scan_flags = '0;
            if (bt.alpha != 0) scan_flags.any_alpha = 1'b1;
            if (bt.mask_byte != 0 && (bt.red | bt.green | bt.blue) != 0)
                scan_flags.masked_conflict = 1'b1;
            if (bt.blue != 0 && bt.mask_byte != 0) scan_flags.mono_conflict = 1'b1;
            return 1'b0;
        end
        if (colour_bitmap_model) begin
            if (scan_flags.any_alpha) begin
                tx.cursor_type = CT_COLOUR;
                tx.red   = alpha_scaled(bt.red, bt.alpha);
                tx.green = alpha_scaled(bt.green, bt.alpha);
                tx.blue  = alpha_scaled(bt.blue, bt.alpha);
                tx.alpha = 8'd255 - bt.alpha;
            end else if (!scan_flags.masked_conflict) begin
                tx.cursor_type = CT_COLOUR;
                if (bt.mask_byte == 0) begin
                    tx.red   = bt.red;
                    tx.green = bt.green;
                    tx.blue  = bt.blue;
                    tx.alpha = bt.alpha;
                end else begin
                    tx.alpha = 8'd255;
                end
            end else begin
                tx.cursor_type = CT_MASKED;
                tx.red   = bt.red;
                tx.green = bt.green;
                tx.blue  = bt.blue;
                tx.alpha = bt.mask_byte;
            end
        end else if (!scan_flags.mono_conflict) begin
            tx.cursor_type = CT_COLOUR;
            if (bt.blue != 0) begin
                tx.alpha = 8'd255;
            end else if (bt.mask_byte != 0) begin
                tx.red   = 8'd255;
                tx.green = 8'd255;
                tx.blue  = 8'd255;
            end
        end else begin
            tx.cursor_type = CT_MONO;
            tx.red   = bt.blue;
            tx.green = bt.mask_byte;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Drive input beats in bursts; predict each accepted beat
    always @(posedge aclk) begin : drive_beats
        pixel_beat_t nxt;
        texel_t      tx;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                beats_accepted <= beats_accepted + 1;
                if (apply_pixel_beat(offered, tx)) expected_texels.push_back(tx);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    nxt = pending_beats.pop_front();
                    offered     <= nxt;
                    s_operation <= nxt.op;
                    s_first     <= nxt.first;
                    s_blue      <= nxt.blue;
                    s_green     <= nxt.green;
                    s_red       <= nxt.red;
                    s_alpha     <= nxt.alpha;
                    s_mask_byte <= nxt.mask_byte;
                    s_valid     <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        if ($urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 9) == 0)
                            gap_left = $urandom_range(10, 24);
                        else
                            gap_left = $urandom_range(1, 4);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each texel beat against the oldest expectation; pace m_ready
    always @(posedge aclk) begin : check_texels
        texel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_texels.size() == 0) begin
                    $error("texel beat with nothing expected: type %0d rgba %0d %0d %0d %0d",
                           m_cursor_type, m_out_red, m_out_green, m_out_blue, m_out_alpha);
                    mismatches++;
                end else begin
                    want = expected_texels.pop_front();
                    check_field("cursor_type", want.cursor_type, m_cursor_type);
                    check_field("out_red", want.red, m_out_red);
                    check_field("out_green", want.green, m_out_green);
                    check_field("out_blue", want.blue, m_out_blue);
                    check_field("out_alpha", want.alpha, m_out_alpha);
                end
                texels_checked++;
            end
            rx_tick++;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (texels_checked >= next_hold_at) begin
                // hold off long enough for the block to back up its input
                hold_left = HoldCycles - 1;
                next_hold_at += HoldEvery;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= (rx_tick % 5) >= 2;
                endcase
            end
        end
    end

    // Configuration write channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                colour_bitmap_model <= cfg_colour_bitmap_present;
                cfg_writes_done     <= cfg_writes_done + 1;
            end
            if (!cfg_valid || cfg_ready) begin
                if (cfg_requests.size() != 0) begin
                    cfg_colour_bitmap_present <= cfg_requests.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Abandon the run when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("cursor_pixel_format_converter: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Argument order follows the input fields: blue, green, red, alpha, mask
    task automatic push_beat(input op_t op, input logic first, input logic [7:0] b,
                             input logic [7:0] g, input logic [7:0] r,
                             input logic [7:0] a, input logic [7:0] m);
        pixel_beat_t bt;
        bt = '{op: op, first: first, blue: b, green: g, red: r, alpha: a, mask_byte: m};
        pending_beats.push_back(bt);
        beats_queued++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One cursor: scan pass with first on pixel zero, then the same pixels converted
    task automatic push_cursor();
        pixel_beat_t   pix[$];
        pixel_beat_t   bt;
        cursor_style_t style;
        int            n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        style = cursor_style_t'($urandom_range(0, 3));
        for (int i = 0; i < n; i++) begin
            bt = '0;
            case (style)
                STYLE_ALPHA: begin
                    bt.blue  = pick_byte();
                    bt.green = pick_byte();
                    bt.red   = pick_byte();
                    bt.alpha = pick_byte();
                    bt.mask_byte = pick_byte();
                end
                STYLE_MASKED: begin
                    if ($urandom_range(0, 9) == 0) begin
                        // colour under a set mask bit
                        bt.blue = pick_byte();
                        bt.green = pick_byte();
                        bt.red = pick_byte();
                        bt.mask_byte = pick_byte();
                    end else if ($urandom_range(0, 1) == 0) begin
                        bt.blue = pick_byte();
                        bt.green = pick_byte();
                        bt.red = pick_byte();
                    end else begin
                        bt.mask_byte = 8'($urandom_range(1, 255));
                    end
                end
                STYLE_MONO: begin
                    bt.blue = ($urandom_range(0, 1) == 0) ? 8'h00 : pick_byte();
                    bt.mask_byte = ($urandom_range(0, 1) == 0) ? 8'h00 : pick_byte();
                    bt.green = pick_byte();
                    bt.red = pick_byte();
                    if ($urandom_range(0, 7) == 0) bt.alpha = pick_byte();
                    // keep AND and XOR apart unless a conflict is wanted
                    if ($urandom_range(0, 7) != 0 && bt.blue != 0) bt.mask_byte = 8'h00;
                end
                default: begin
                    bt.blue  = pick_byte();
                    bt.green = pick_byte();
                    bt.red   = pick_byte();
                    bt.alpha = pick_byte();
                    bt.mask_byte = pick_byte();
                end
            endcase
            pix.push_back(bt);
        end
        foreach (pix[i])
            push_beat(OP_SCAN, i == 0, pix[i].blue, pix[i].green, pix[i].red,
                      pix[i].alpha, pix[i].mask_byte);
        foreach (pix[i])
            push_beat(OP_CONVERT, $urandom_range(0, 7) == 0, pix[i].blue, pix[i].green,
                      pix[i].red, pix[i].alpha, pix[i].mask_byte);
    endtask

    task automatic push_random_phase(input int count);
        int start;
        start = beats_queued;
        while (beats_queued - start < count) begin
            if ($urandom_range(0, 6) == 0)
                push_beat(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
            else
                push_cursor();
        end
    endtask

    // Wait until every beat is taken and every texel checked, then let the pipe empty
    task automatic drain(input int settle);
        while (beats_accepted != beats_queued || expected_texels.size() != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_colour_bitmap(input logic value);
        drain(4);
        cfg_requests.push_back(value);
        cfg_writes_asked++;
        while (cfg_writes_done != cfg_writes_asked) @(negedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Monochrome register at reset; convert before any scan uses cleared flags
        push_beat(OP_CONVERT, 1'b1, 8'h00, 8'h12, 8'h34, 8'h56, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
        push_beat(OP_CONVERT, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h80);
        push_beat(OP_SCAN,    1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
        push_beat(OP_SCAN,    1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
        // AND and XOR both set: two-channel output; first on a convert changes nothing
        push_beat(OP_SCAN,    1'b0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01);
        push_beat(OP_CONVERT, 1'b0, 8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'h55);
        push_beat(OP_CONVERT, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        // Colour bitmap: stale masked conflict, then convertible mask, then alpha
        write_colour_bitmap(1'b1);
        push_beat(OP_CONVERT, 1'b0, 8'h03, 8'h02, 8'h01, 8'h00, 8'h80);
        push_beat(OP_SCAN,    1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
        push_beat(OP_SCAN,    1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'h30, 8'h20, 8'h10, 8'h40, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'h30, 8'h20, 8'h10, 8'h40, 8'hFF);
        push_beat(OP_SCAN,    1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'h7F, 8'h80, 8'h01, 8'h01, 8'h00);
        push_beat(OP_CONVERT, 1'b0, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'hFF);
        push_beat(OP_SCAN,    1'b1, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01);
        push_beat(OP_CONVERT, 1'b0, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00);

        // Random cursors across register settings
        write_colour_bitmap(1'b0);
        push_random_phase(100);
        write_colour_bitmap(1'b1);
        push_random_phase(100);
        write_colour_bitmap(1'b0);
        push_random_phase(100);
        write_colour_bitmap(1'b1);
        push_random_phase(100);
        write_colour_bitmap(1'b1);
        push_random_phase(100);
        write_colour_bitmap(1'b0);
        push_random_phase(100);
        drain(8);

        if (expected_texels.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("cursor_pixel_format_converter: match");
        end else begin
            $display("cursor_pixel_format_converter: mismatch");
        end
        $finish;
    end

endmodule
